// ----- hdl/sarl_pkg.sv -----
// ----------------------------------------------------------------------------
// sarl_pkg
// Shared types and constants for the sector-aligned record logger.
// ----------------------------------------------------------------------------
package sarl_pkg;

  localparam int unsigned SECTOR_WORDS = 128;
  localparam int unsigned MAX_FIELDS   = 32;

  typedef enum logic [2:0] {
    ACT_START     = 3'd0,
    ACT_SET_FIELD = 3'd1,
    ACT_TICK      = 3'd2,
    ACT_DRAIN     = 3'd3,
    ACT_REQ_STOP  = 3'd4,
    ACT_STOP_NOW  = 3'd5,
    ACT_WR_RESULT = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_REC   = 3'd1,
    MODE_FLUSH = 3'd2,
    MODE_FULL  = 3'd3,
    MODE_ERR   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DIV,
    SQ_PAD,
    SQ_PUSH,
    SQ_RD_LO,
    SQ_RD_HI,
    SQ_EMIT
  } seq_t;

  localparam logic [2:0] REG_DECIMATION  = 3'd0;
  localparam logic [2:0] REG_REC_LIMIT   = 3'd1;
  localparam logic [2:0] REG_FIELD_COUNT = 3'd2;
  localparam logic [2:0] REG_BASE_LBA    = 3'd3;

endpackage

// ----- hdl/sector_aligned_record_logger.sv -----
// ----------------------------------------------------------------------------
// sector_aligned_record_logger
// Logs decimated records into a word ring and drains it one sector at a time.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in_ channel (valid/stall); every command
// yields one status beat on the out_ channel, except a drain that sends a
// sector, which yields 64 data beats (two ring words each, last one flagged).
// Registers are written on the cfg_ channel, which is always ready.
// One command at a time is in work; in_stall stays high until its final beat
// has left the output register.
// A tick in recording runs a bit-serial remainder for decimation, then one
// ring write per cycle: at most 32 pad words, a room check, then the record
// words (timestamp plus field words). A sector drain runs a bit-serial
// divide for the record count, then reads each beat's two ring words through
// the single ring read port before it emits the beat.
// Out stall simply holds the current beat; the sequencer waits behind it.
// Reset (rst_n low, synchronous) clears control, counters and field words;
// the ring memory is not cleared and is only read where it was written.
module sector_aligned_record_logger #(
  parameter int unsigned RING_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [4:0]  in_field_index,
  input  logic [31:0] in_field_value,
  input  logic [31:0] in_timestamp_ms,
  input  logic        in_write_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_sector_beat,
  output logic [63:0] out_beat_data,
  output logic        out_beat_last,
  output logic [31:0] out_sector_address,
  output logic [2:0]  out_log_state,
  output logic [31:0] out_flushed_count,
  output logic [31:0] out_overrun_count,
  output logic [31:0] out_sectors_written_count,
  output logic [31:0] out_write_error_count,
  output logic        out_sector_ready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(RING_WORDS);
  localparam logic [AW:0] RING_FULL = (AW+1)'(RING_WORDS);
  localparam logic [AW:0] SEC_FILL  = (AW+1)'(sarl_pkg::SECTOR_WORDS);
  localparam logic [7:0]  SEC_W8    = 8'(sarl_pkg::SECTOR_WORDS);
  localparam logic [7:0]  LAST_WORD = 8'(sarl_pkg::SECTOR_WORDS - 1);

  // configuration
  logic [15:0] dec_r;
  logic [31:0] maxr_r, base_r;
  logic [5:0]  nf_r;

  // control and counters
  sarl_pkg::seq_t  seq_r, seq_nxt;
  sarl_pkg::mode_t mode_r, mode_nxt;
  logic stop_r, stop_nxt, swait_r, swait_nxt, wpend_r, wpend_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AW:0] fill_r, fill_nxt;
  logic [31:0] tick_r, tick_nxt, rec_r, rec_nxt, flush_r, flush_nxt;
  logic [31:0] addr_r, addr_nxt, ovr_r, ovr_nxt, sect_r, sect_nxt;
  logic [31:0] werr_r, werr_nxt;
  logic [31:0] fields_r [sarl_pkg::MAX_FIELDS];
  logic        fwe;

  // sequencer payload
  logic [31:0] ts_r, ts_nxt, lo_r, lo_nxt;
  logic [7:0]  cnt_r, cnt_nxt, take_r, take_nxt;
  logic        div_drain_r, div_drain_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dsr_r, dsr_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt, out_sec_r, out_sec_nxt;
  logic        out_last_r, out_last_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  // ring memory
  logic [31:0] ring_mem [RING_WORDS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, rd_q;

  logic [5:0]  nf_c, rs;
  logic [16:0] rem_s, rem_step;
  logic        ge;
  logic [31:0] dv_step;
  logic [7:0]  off8, pad8;
  logic [AW:0] room;
  logic        out_free;
  logic [AW-1:0] head_inc;

  assign nf_c = (nf_r == 6'd0) ? 6'd1 :
                (nf_r > 6'(sarl_pkg::MAX_FIELDS)) ? 6'(sarl_pkg::MAX_FIELDS) : nf_r;
  assign rs   = nf_c + 6'd1;
  assign room = RING_FULL - fill_r;
  assign head_inc = (head_r == AW'(RING_WORDS - 1)) ? '0 : head_r + AW'(1);
  assign off8 = {1'b0, head_r[6:0]};

  // one restoring-division step
  assign rem_s    = {rem_r[15:0], dv_r[31]};
  assign ge       = rem_s >= {1'b0, dsr_r};
  assign rem_step = ge ? rem_s - {1'b0, dsr_r} : rem_s;
  assign dv_step  = {dv_r[30:0], ge};

  assign in_stall  = out_valid_r | (seq_r != sarl_pkg::SQ_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid                 = out_valid_r;
  assign out_is_sector_beat        = out_sec_r;
  assign out_beat_data             = out_data_r;
  assign out_beat_last             = out_last_r;
  assign out_sector_address        = addr_r;
  assign out_log_state             = mode_r;
  assign out_flushed_count         = flush_r;
  assign out_overrun_count         = ovr_r;
  assign out_sectors_written_count = sect_r;
  assign out_write_error_count     = werr_r;
  assign out_sector_ready          = swait_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= ring_mem[mem_raddr];
    end
  end

  always_comb begin
    seq_nxt = seq_r; mode_nxt = mode_r; stop_nxt = stop_r; swait_nxt = swait_r;
    wpend_nxt = wpend_r; pend_nxt = pend_r; head_nxt = head_r; tail_nxt = tail_r;
    fill_nxt = fill_r; tick_nxt = tick_r; rec_nxt = rec_r; flush_nxt = flush_r;
    addr_nxt = addr_r; ovr_nxt = ovr_r; sect_nxt = sect_r; werr_nxt = werr_r;
    ts_nxt = ts_r; lo_nxt = lo_r; cnt_nxt = cnt_r; take_nxt = take_r;
    div_drain_nxt = div_drain_r; dv_nxt = dv_r; rem_nxt = rem_r; dsr_nxt = dsr_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_sec_nxt = out_sec_r; out_last_nxt = out_last_r; out_data_nxt = out_data_r;
    mem_we = 1'b0; mem_waddr = head_r; mem_wdata = '0;
    mem_re = 1'b0; mem_raddr = tail_r;
    fwe = 1'b0;
    pad8 = '0;

    unique case (seq_r)
      sarl_pkg::SQ_IDLE: begin
        if (in_valid && !in_stall) begin
          out_valid_nxt = 1'b1; out_sec_nxt = 1'b0;
          out_data_nxt = '0;    out_last_nxt = 1'b1;
          unique case (in_action)
            sarl_pkg::ACT_START: begin
              rec_nxt = '0; flush_nxt = '0; tick_nxt = '0; addr_nxt = base_r + 32'd1;
              head_nxt = '0; tail_nxt = '0; fill_nxt = '0; swait_nxt = 1'b0;
              stop_nxt = 1'b0; wpend_nxt = 1'b0; pend_nxt = '0; ovr_nxt = '0;
              sect_nxt = '0; werr_nxt = '0; mode_nxt = sarl_pkg::MODE_REC;
            end
            sarl_pkg::ACT_SET_FIELD: fwe = 1'b1;
            sarl_pkg::ACT_TICK: begin
              if (mode_r == sarl_pkg::MODE_REC) begin
                out_valid_nxt = 1'b0;
                tick_nxt = tick_r + 32'd1;
                ts_nxt = in_timestamp_ms;
                dv_nxt = tick_r + 32'd1; rem_nxt = '0;
                dsr_nxt = (dec_r == 16'd0) ? 16'd1 : dec_r;
                div_drain_nxt = 1'b0; cnt_nxt = '0;
                seq_nxt = sarl_pkg::SQ_DIV;
              end
            end
            sarl_pkg::ACT_DRAIN: begin
              if (wpend_r || (mode_r != sarl_pkg::MODE_REC &&
                              mode_r != sarl_pkg::MODE_FLUSH)) begin
              end else if (mode_r == sarl_pkg::MODE_REC && fill_r < SEC_FILL) begin
              end else if (fill_r == '0) begin
                mode_nxt = sarl_pkg::MODE_IDLE;
              end else begin
                out_valid_nxt = 1'b0;
                take_nxt = (fill_r >= SEC_FILL) ? SEC_W8 : 8'(fill_r);
                fill_nxt = fill_r - ((fill_r >= SEC_FILL) ? SEC_FILL : fill_r);
                wpend_nxt = 1'b1;
                dv_nxt = (fill_r >= SEC_FILL) ? 32'(SEC_W8) : 32'(fill_r);
                rem_nxt = '0; dsr_nxt = 16'(rs);
                div_drain_nxt = 1'b1; cnt_nxt = '0;
                seq_nxt = sarl_pkg::SQ_DIV;
              end
            end
            sarl_pkg::ACT_REQ_STOP: begin
              if (mode_r == sarl_pkg::MODE_REC) stop_nxt = 1'b1;
            end
            sarl_pkg::ACT_STOP_NOW: begin
              if (mode_r == sarl_pkg::MODE_REC || mode_r == sarl_pkg::MODE_FLUSH ||
                  mode_r == sarl_pkg::MODE_FULL) mode_nxt = sarl_pkg::MODE_FLUSH;
            end
            sarl_pkg::ACT_WR_RESULT: begin
              if (wpend_r) begin
                wpend_nxt = 1'b0;
                if (!in_write_ok) begin
                  werr_nxt = werr_r + 32'd1;
                  mode_nxt = sarl_pkg::MODE_ERR;
                end else begin
                  addr_nxt = addr_r + 32'd1;
                  sect_nxt = sect_r + 32'd1;
                  flush_nxt = flush_r + 32'(pend_r);
                  swait_nxt = fill_r >= SEC_FILL;
                end
              end
            end
            default: ;
          endcase
        end
      end

      sarl_pkg::SQ_DIV: begin
        dv_nxt = dv_step; rem_nxt = rem_step; cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'd31) begin
          cnt_nxt = '0;
          if (div_drain_r) begin
            pend_nxt = dv_step[7:0];
            seq_nxt = sarl_pkg::SQ_RD_LO;
          end else if (rem_step != '0) begin
            seq_nxt = sarl_pkg::SQ_IDLE; out_valid_nxt = 1'b1;
            out_sec_nxt = 1'b0; out_data_nxt = '0; out_last_nxt = 1'b1;
          end else if (rec_r >= maxr_r) begin
            mode_nxt = sarl_pkg::MODE_FULL;
            seq_nxt = sarl_pkg::SQ_IDLE; out_valid_nxt = 1'b1;
            out_sec_nxt = 1'b0; out_data_nxt = '0; out_last_nxt = 1'b1;
          end else if (stop_r) begin
            mode_nxt = sarl_pkg::MODE_FLUSH;
            seq_nxt = sarl_pkg::SQ_IDLE; out_valid_nxt = 1'b1;
            out_sec_nxt = 1'b0; out_data_nxt = '0; out_last_nxt = 1'b1;
          end else begin
            if (off8 + 8'(rs) > SEC_W8) begin
              pad8 = SEC_W8 - off8;
              if ((AW+1)'(pad8) > room) pad8 = 8'(room);
              cnt_nxt = pad8;
              swait_nxt = 1'b1;
            end
            seq_nxt = sarl_pkg::SQ_PAD;
          end
        end
      end

      sarl_pkg::SQ_PAD: begin
        if (cnt_r != 8'd0) begin
          mem_we = 1'b1; mem_wdata = '0;
          head_nxt = head_inc; fill_nxt = fill_r + (AW+1)'(1);
          cnt_nxt = cnt_r - 8'd1;
        end else if (room < (AW+1)'(rs)) begin
          ovr_nxt = ovr_r + 32'd1;
          seq_nxt = sarl_pkg::SQ_IDLE; out_valid_nxt = 1'b1;
          out_sec_nxt = 1'b0; out_data_nxt = '0; out_last_nxt = 1'b1;
        end else begin
          seq_nxt = sarl_pkg::SQ_PUSH;
        end
      end

      sarl_pkg::SQ_PUSH: begin
        mem_we = 1'b1;
        mem_wdata = (cnt_r == 8'd0) ? ts_r : fields_r[5'(cnt_r - 8'd1)];
        head_nxt = head_inc; fill_nxt = fill_r + (AW+1)'(1);
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'(nf_c)) begin
          if (head_inc[6:0] == 7'd0) swait_nxt = 1'b1;
          rec_nxt = rec_r + 32'd1;
          seq_nxt = sarl_pkg::SQ_IDLE; out_valid_nxt = 1'b1;
          out_sec_nxt = 1'b0; out_data_nxt = '0; out_last_nxt = 1'b1;
        end
      end

      sarl_pkg::SQ_RD_LO: begin
        if (cnt_r < take_r) begin
          mem_re = 1'b1;
          tail_nxt = (tail_r == AW'(RING_WORDS - 1)) ? '0 : tail_r + AW'(1);
        end
        seq_nxt = sarl_pkg::SQ_RD_HI;
      end

      sarl_pkg::SQ_RD_HI: begin
        lo_nxt = (cnt_r < take_r) ? rd_q : '0;
        if (cnt_r + 8'd1 < take_r) begin
          mem_re = 1'b1;
          tail_nxt = (tail_r == AW'(RING_WORDS - 1)) ? '0 : tail_r + AW'(1);
        end
        cnt_nxt = cnt_r + 8'd1;
        seq_nxt = sarl_pkg::SQ_EMIT;
      end

      sarl_pkg::SQ_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1; out_sec_nxt = 1'b1;
          out_data_nxt = {((cnt_r < take_r) ? rd_q : 32'd0), lo_r};
          out_last_nxt = (cnt_r == LAST_WORD);
          cnt_nxt = cnt_r + 8'd1;
          seq_nxt = (cnt_r == LAST_WORD) ? sarl_pkg::SQ_IDLE : sarl_pkg::SQ_RD_LO;
        end
      end

      default: seq_nxt = sarl_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= 16'd1; maxr_r <= 32'd1; nf_r <= 6'd1; base_r <= '0;
      seq_r <= sarl_pkg::SQ_IDLE; mode_r <= sarl_pkg::MODE_IDLE;
      stop_r <= 1'b0; swait_r <= 1'b0; wpend_r <= 1'b0; pend_r <= '0;
      head_r <= '0; tail_r <= '0; fill_r <= '0;
      tick_r <= '0; rec_r <= '0; flush_r <= '0; addr_r <= '0;
      ovr_r <= '0; sect_r <= '0; werr_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < int'(sarl_pkg::MAX_FIELDS); i++) fields_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sarl_pkg::REG_DECIMATION:  dec_r  <= cfg_wdata[15:0];
          sarl_pkg::REG_REC_LIMIT:   maxr_r <= cfg_wdata;
          sarl_pkg::REG_FIELD_COUNT: nf_r   <= cfg_wdata[5:0];
          sarl_pkg::REG_BASE_LBA:    base_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (fwe) fields_r[in_field_index] <= in_field_value;
      seq_r <= seq_nxt; mode_r <= mode_nxt;
      stop_r <= stop_nxt; swait_r <= swait_nxt; wpend_r <= wpend_nxt; pend_r <= pend_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; fill_r <= fill_nxt;
      tick_r <= tick_nxt; rec_r <= rec_nxt; flush_r <= flush_nxt; addr_r <= addr_nxt;
      ovr_r <= ovr_nxt; sect_r <= sect_nxt; werr_r <= werr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r <= ts_nxt; lo_r <= lo_nxt; cnt_r <= cnt_nxt; take_r <= take_nxt;
    div_drain_r <= div_drain_nxt; dv_r <= dv_nxt; rem_r <= rem_nxt; dsr_r <= dsr_nxt;
    out_sec_r <= out_sec_nxt; out_last_r <= out_last_nxt; out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= RING_FULL) else $error("ring fill count above capacity");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_sector_beat) |-> out_beat_last)
    else $error("status beat without last flag");

  a_push_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == sarl_pkg::SQ_PUSH || seq_r == sarl_pkg::SQ_PAD) |->
      (mode_r == sarl_pkg::MODE_REC))
    else $error("ring write outside recording");

  a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == sarl_pkg::SQ_EMIT) |-> wpend_r)
    else $error("sector beat without pending write");
`endif

endmodule
